>>> rtl/rtp_jpeg_packetizer_top_assert.svh
// Assertion macros for the packetizer top level.
`ifndef RTP_JPEG_PACKETIZER_TOP_ASSERT_SVH
`define RTP_JPEG_PACKETIZER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RJP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rtp_jpeg_packetizer: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define RJP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rtp_jpeg_packetizer: next-cycle check failed");

`endif

>>> rtl/rjp_pkg.sv
package rjp_pkg;

    // Register indexes on the configuration port.
    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] CFG_PAYLOAD_TYPE  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE_ID     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DECIM_SCALE   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_INCL_TABLES   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT  = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_PAYLOAD_MAX   = 3'd6;

    // Reset values.
    localparam logic [7:0]  RST_DECIM_SCALE = 8'd1;
    localparam logic        RST_INCL_TABLES = 1'b1;
    localparam logic [15:0] RST_IMAGE_SIZE  = 16'd0;
    localparam logic [10:0] RST_PAYLOAD_MAX = 11'd1400;

    // Command codes.
    localparam logic CMD_FRAME = 1'b0;
    localparam logic CMD_NEXT  = 1'b1;

    // 90 kHz clock: seconds * 90000, microseconds * 9 / 100.
    localparam logic [31:0] TS_SEC_SCALE = 32'd90000;
    // ceil(2^31 / 100); exact floor for any 24-bit dividend.
    localparam logic [24:0] TS_FRAC_RECIP = 25'd21474837;
    localparam int          TS_FRAC_SHIFT = 31;

    localparam logic [10:0] TABLE_BLOCK_BYTES = 11'd132;
    localparam logic [15:0] SIZE_LIMIT        = 16'd2040;

    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        K_START = 2'd0,
        K_NEXT  = 2'd1,
        K_ABORT = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [23:0] length;
        logic [7:0]  quality;
        logic [31:0] timestamp;
    } t_cmd;

    typedef struct packed {
        logic        incl_tables;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic [10:0] payload_max;
    } t_cfg;

    typedef struct packed {
        logic active;
        logic emit_last;
    } t_back_status;

endpackage

>>> rtl/rtp_jpeg_packetizer_top.sv
// Channel   Direction  Handshake              Payload
// -------   ---------  ---------------------  --------------------------------------
// request   in         push / full            command, frame length/quality, capture time
// result    out        empty / pop            RTP/JPEG header fields of one packet
// config    in         cfg_valid / cfg_ready  register index (3b), write data (32b)
//
// Takes one request per clock while full is low; a request's packet passes through the
// two timestamp multiply stages, the command queue and the result register to the result
// ports. The front keeps taking requests while a result waits, until its stages and the
// command queue (QUEUE_DEPTH entries) fill. Synchronous active-low reset clears all
// control state and the byte, offset and sequence counters; config registers return to
// their defaults. Config write accepted every cycle; payload type and source id are
// accepted but shape no result field, so they are not stored.

`include "rtp_jpeg_packetizer_top_assert.svh"

module rtp_jpeg_packetizer_top #(
    parameter int QUEUE_DEPTH = rjp_pkg::QUEUE_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // request channel
    input  logic                            push,
    output logic                            full,
    input  logic                            i_command,
    input  logic [23:0]                     i_frame_length,
    input  logic [7:0]                      i_frame_quality,
    input  logic [31:0]                     i_capture_seconds,
    input  logic [19:0]                     i_capture_microseconds,
    // result channel
    output logic                            empty,
    input  logic                            pop,
    output logic [15:0]                     o_sequence_number,
    output logic [31:0]                     o_rtp_timestamp,
    output logic                            o_marker,
    output logic [23:0]                     o_fragment_offset,
    output logic [10:0]                     o_payload_length,
    output logic                            o_first_packet,
    output logic [7:0]                      o_q_byte,
    output logic [7:0]                      o_width_byte,
    output logic [7:0]                      o_height_byte,
    // config channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [rjp_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [31:0]                     i_cfg_data
);

    // Config registers.
    logic [7:0]  r_decim_scale;
    logic        r_incl_tables;
    logic [15:0] r_image_width;
    logic [15:0] r_image_height;
    logic [10:0] r_payload_max;

    rjp_pkg::t_cfg         back_cfg;
    rjp_pkg::t_cmd         enq_cmd;
    rjp_pkg::t_cmd         deq_cmd;
    rjp_pkg::t_back_status back_status;
    logic                  enq_valid;
    logic                  enq_ready;
    logic                  deq_valid;
    logic                  deq_ready;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decim_scale  <= rjp_pkg::RST_DECIM_SCALE;
            r_incl_tables  <= rjp_pkg::RST_INCL_TABLES;
            r_image_width  <= rjp_pkg::RST_IMAGE_SIZE;
            r_image_height <= rjp_pkg::RST_IMAGE_SIZE;
            r_payload_max  <= rjp_pkg::RST_PAYLOAD_MAX;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                rjp_pkg::CFG_DECIM_SCALE: begin
                    r_decim_scale <= i_cfg_data[7:0];
                end
                rjp_pkg::CFG_INCL_TABLES: begin
                    r_incl_tables <= i_cfg_data[0];
                end
                rjp_pkg::CFG_IMAGE_WIDTH: begin
                    r_image_width <= i_cfg_data[15:0];
                end
                rjp_pkg::CFG_IMAGE_HEIGHT: begin
                    r_image_height <= i_cfg_data[15:0];
                end
                rjp_pkg::CFG_PAYLOAD_MAX: begin
                    r_payload_max <= i_cfg_data[10:0];
                end
                default: begin
                    // payload type, source id and unused indexes: nothing kept
                end
            endcase
        end
    end

    assign back_cfg.incl_tables  = r_incl_tables;
    assign back_cfg.image_width  = r_image_width;
    assign back_cfg.image_height = r_image_height;
    assign back_cfg.payload_max  = r_payload_max;

    // Front: accepts requests, runs decimation, builds the 90 kHz timestamp.
    rjp_front u_front (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_push                 (push),
        .o_full                 (full),
        .i_command              (i_command),
        .i_frame_length         (i_frame_length),
        .i_frame_quality        (i_frame_quality),
        .i_capture_seconds      (i_capture_seconds),
        .i_capture_microseconds (i_capture_microseconds),
        .i_decim_scale          (r_decim_scale),
        .o_enq_valid            (enq_valid),
        .i_enq_ready            (enq_ready),
        .o_enq_cmd              (enq_cmd)
    );

    // Classified commands wait here so each side stalls on its own.
    rjp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (enq_valid),
        .o_wr_ready (enq_ready),
        .i_wr_cmd   (enq_cmd),
        .o_rd_valid (deq_valid),
        .i_rd_ready (deq_ready),
        .o_rd_cmd   (deq_cmd)
    );

    // Back: frame fragmentation state and the result register.
    rjp_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (back_cfg),
        .i_cmd_valid       (deq_valid),
        .o_cmd_ready       (deq_ready),
        .i_cmd             (deq_cmd),
        .o_empty           (empty),
        .i_pop             (pop),
        .o_sequence_number (o_sequence_number),
        .o_rtp_timestamp   (o_rtp_timestamp),
        .o_marker          (o_marker),
        .o_fragment_offset (o_fragment_offset),
        .o_payload_length  (o_payload_length),
        .o_first_packet    (o_first_packet),
        .o_q_byte          (o_q_byte),
        .o_width_byte      (o_width_byte),
        .o_height_byte     (o_height_byte),
        .o_status          (back_status)
    );

    // First packet starts the frame at offset zero; later ones never do.
    `RJP_ASSERT_NOW(a_first_at_zero, !empty && o_first_packet, o_fragment_offset == 24'd0)
    `RJP_ASSERT_NOW(a_later_offset, !empty && !o_first_packet, o_fragment_offset != 24'd0)
    // A packet always carries frame bytes.
    `RJP_ASSERT_NOW(a_len_nonzero, !empty, o_payload_length != 11'd0)
    // The marker packet closes the frame.
    `RJP_ASSERT_NEXT(a_marker_ends, back_status.emit_last, !back_status.active)

endmodule

>>> rtl/rjp_front.sv
module rjp_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  logic               i_command,
    input  logic [23:0]        i_frame_length,
    input  logic [7:0]         i_frame_quality,
    input  logic [31:0]        i_capture_seconds,
    input  logic [19:0]        i_capture_microseconds,
    input  logic [7:0]         i_decim_scale,
    output logic               o_enq_valid,
    input  logic               i_enq_ready,
    output rjp_pkg::t_cmd      o_enq_cmd
);

    logic a_ready;
    logic b_ready;
    logic accept;
    logic is_frame;
    logic zero_len;
    logic load_a;
    logic [8:0] cnt_inc;
    rjp_pkg::t_kind kind;
    logic [31:0] sec_prod;
    logic [23:0] usec9;

    logic [7:0]     r_decim_cnt;
    logic           r_a_valid;
    rjp_pkg::t_kind r_a_kind;
    logic [23:0]    r_a_length;
    logic [7:0]     r_a_quality;
    logic [31:0]    r_a_sec_prod;
    logic [23:0]    r_a_usec9;
    logic           r_b_valid;
    rjp_pkg::t_kind r_b_kind;
    logic [23:0]    r_b_length;
    logic [7:0]     r_b_quality;
    logic [31:0]    r_b_sec_prod;
    logic [48:0]    r_b_frac_prod;

    assign b_ready = !r_b_valid || i_enq_ready;
    assign a_ready = !r_a_valid || b_ready;
    assign o_full  = !a_ready;
    assign accept  = i_push && a_ready;

    assign is_frame = (i_command == rjp_pkg::CMD_FRAME);
    assign zero_len = (i_frame_length == 24'd0);
    // Zero-length frames vanish here.
    assign load_a   = accept && !(is_frame && zero_len);
    assign cnt_inc  = {1'b0, r_decim_cnt} + 9'd1;

    always_comb begin
        if (!is_frame) begin
            kind = rjp_pkg::K_NEXT;
        end else if (r_decim_cnt != 8'd0) begin
            kind = rjp_pkg::K_ABORT;
        end else begin
            kind = rjp_pkg::K_START;
        end
    end

    assign sec_prod = i_capture_seconds * rjp_pkg::TS_SEC_SCALE;
    assign usec9    = 24'({i_capture_microseconds, 3'b000}) + 24'(i_capture_microseconds);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decim_cnt <= 8'd0;
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
        end else begin
            if (accept && is_frame && !zero_len) begin
                r_decim_cnt <= (cnt_inc >= {1'b0, i_decim_scale}) ? 8'd0 : cnt_inc[7:0];
            end
            if (a_ready) begin
                r_a_valid <= load_a;
            end
            if (b_ready) begin
                r_b_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_ready && load_a) begin
            r_a_kind     <= kind;
            r_a_length   <= i_frame_length;
            r_a_quality  <= i_frame_quality;
            r_a_sec_prod <= sec_prod;
            r_a_usec9    <= usec9;
        end
        if (b_ready && r_a_valid) begin
            r_b_kind      <= r_a_kind;
            r_b_length    <= r_a_length;
            r_b_quality   <= r_a_quality;
            r_b_sec_prod  <= r_a_sec_prod;
            r_b_frac_prod <= 49'(r_a_usec9) * 49'(rjp_pkg::TS_FRAC_RECIP);
        end
    end

    assign o_enq_valid          = r_b_valid;
    assign o_enq_cmd.kind       = r_b_kind;
    assign o_enq_cmd.length     = r_b_length;
    assign o_enq_cmd.quality    = r_b_quality;
    assign o_enq_cmd.timestamp  = r_b_sec_prod
                                + 32'(r_b_frac_prod[48:rjp_pkg::TS_FRAC_SHIFT]);

endmodule

>>> rtl/rjp_queue.sv
module rjp_queue #(
    parameter int DEPTH = rjp_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr_valid,
    output logic          o_wr_ready,
    input  rjp_pkg::t_cmd i_wr_cmd,
    output logic          o_rd_valid,
    input  logic          i_rd_ready,
    output rjp_pkg::t_cmd o_rd_cmd
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    rjp_pkg::t_cmd    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             wr;
    logic             rd;

    assign o_wr_ready = (r_count != CNT_W'(DEPTH));
    assign o_rd_valid = (r_count != '0);
    assign o_rd_cmd   = r_mem[r_rd_ptr];
    assign wr         = i_wr_valid && o_wr_ready;
    assign rd         = o_rd_valid && i_rd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (wr && !rd) begin
                r_count <= r_count + 1'b1;
            end else if (rd && !wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wr_ptr] <= i_wr_cmd;
        end
    end

endmodule

>>> rtl/rjp_back.sv
module rjp_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  rjp_pkg::t_cfg         i_cfg,
    input  logic                  i_cmd_valid,
    output logic                  o_cmd_ready,
    input  rjp_pkg::t_cmd         i_cmd,
    output logic                  o_empty,
    input  logic                  i_pop,
    output logic [15:0]           o_sequence_number,
    output logic [31:0]           o_rtp_timestamp,
    output logic                  o_marker,
    output logic [23:0]           o_fragment_offset,
    output logic [10:0]           o_payload_length,
    output logic                  o_first_packet,
    output logic [7:0]            o_q_byte,
    output logic [7:0]            o_width_byte,
    output logic [7:0]            o_height_byte,
    output rjp_pkg::t_back_status o_status
);

    function automatic logic [7:0] size_byte(input logic [15:0] px);
        size_byte = (px <= rjp_pkg::SIZE_LIMIT) ? px[10:3] : 8'd0;
    endfunction

    logic        consume;
    logic        is_start;
    logic        emit;
    logic        last;
    logic [23:0] cur_bytes;
    logic [23:0] cur_offset;
    logic [31:0] cur_ts;
    logic [7:0]  cur_q;
    logic [10:0] chunk;
    logic [10:0] len;

    logic        r_active;
    logic [23:0] r_bytes;
    logic [23:0] r_offset;
    logic [15:0] r_seq;
    logic [31:0] r_ts;
    logic [7:0]  r_q;
    logic        r_out_valid;

    // Result register.
    logic [15:0] r_out_seq;
    logic [31:0] r_out_ts;
    logic        r_out_marker;
    logic [23:0] r_out_offset;
    logic [10:0] r_out_len;
    logic        r_out_first;
    logic [7:0]  r_out_q;
    logic [7:0]  r_out_wb;
    logic [7:0]  r_out_hb;

    assign o_cmd_ready = !r_out_valid || i_pop;
    assign consume     = i_cmd_valid && o_cmd_ready;
    assign is_start    = (i_cmd.kind == rjp_pkg::K_START);
    assign emit        = consume && (is_start || (i_cmd.kind == rjp_pkg::K_NEXT && r_active));

    // A start command seeds the packet state directly.
    assign cur_bytes  = is_start ? i_cmd.length    : r_bytes;
    assign cur_offset = is_start ? 24'd0           : r_offset;
    assign cur_ts     = is_start ? i_cmd.timestamp : r_ts;
    assign cur_q      = is_start ? i_cmd.quality   : r_q;

    always_comb begin
        chunk = i_cfg.payload_max;
        if (i_cfg.incl_tables && is_start) begin
            chunk = (chunk > rjp_pkg::TABLE_BLOCK_BYTES) ?
                    chunk - rjp_pkg::TABLE_BLOCK_BYTES : 11'd0;
        end
        if (chunk == 11'd0) begin
            chunk = 11'd1;
        end
    end

    assign last = (cur_bytes <= 24'(chunk));
    assign len  = last ? cur_bytes[10:0] : chunk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_bytes     <= 24'd0;
            r_offset    <= 24'd0;
            r_seq       <= 16'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_active <= !last;
                r_bytes  <= last ? 24'd0 : cur_bytes - 24'(chunk);
                r_offset <= cur_offset + 24'(len);
                r_seq    <= r_seq + 16'd1;
            end else if (consume && i_cmd.kind == rjp_pkg::K_ABORT) begin
                r_active <= 1'b0;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_ts         <= cur_ts;
            r_q          <= cur_q;
            r_out_seq    <= r_seq;
            r_out_ts     <= cur_ts;
            r_out_marker <= last;
            r_out_offset <= cur_offset;
            r_out_len    <= len;
            r_out_first  <= is_start;
            r_out_q      <= {cur_q[7] ^ i_cfg.incl_tables, cur_q[6:0]};
            r_out_wb     <= size_byte(i_cfg.image_width);
            r_out_hb     <= size_byte(i_cfg.image_height);
        end
    end

    assign o_sequence_number  = r_out_seq;
    assign o_rtp_timestamp    = r_out_ts;
    assign o_marker           = r_out_marker;
    assign o_fragment_offset  = r_out_offset;
    assign o_payload_length   = r_out_len;
    assign o_first_packet     = r_out_first;
    assign o_q_byte           = r_out_q;
    assign o_width_byte       = r_out_wb;
    assign o_height_byte      = r_out_hb;

    assign o_empty            = !r_out_valid;
    assign o_status.active    = r_active;
    assign o_status.emit_last = emit && last;

endmodule
